// ===== sv/rti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rti_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int THR_WIDTH   = 16;
  localparam int IDX_WIDTH   = 3;

  // edge / offset vectors carry one extra bit for the subtraction
  localparam int EW    = COORD_WIDTH + 1;
  // cross product components
  localparam int PW    = 2 * EW + 2;
  localparam int LOW_W = PW / 2;
  localparam int HI_W  = PW - LOW_W;
  // dot product results
  localparam int SW    = EW + PW + 2;
  // divider remainder width
  localparam int DVW   = SW + COORD_WIDTH;
  localparam int DIV_STEPS = COORD_WIDTH;
  localparam int TH_SHIFT  = 2 * FRAC_BITS;
  localparam int FRONT_STAGES = 7;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [EW-1:0]          edge_t;
  typedef logic signed [PW-1:0]          cross_t;
  typedef logic signed [SW-1:0]          dot_t;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_DIRECTION_X = 3'd3,
    REG_DIRECTION_Y = 3'd4,
    REG_DIRECTION_Z = 3'd5,
    REG_THRESHOLD   = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic vld;
    logic hit;
    logic tneg;
  } div_ctl_t;
endpackage
`default_nettype wire

// ===== sv/rti_cross.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rti_cross (
  input  wire logic           clk,
  input  wire logic           en,
  input  rti_pkg::edge_t      a [3],
  input  rti_pkg::edge_t      b [3],
  output rti_pkg::cross_t     c [3]
);
  import rti_pkg::*;

  logic signed [2*EW-1:0] m [6];

  // stage 1: six products, stage 2: differences
  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= a[1] * b[2];
      m[1] <= a[2] * b[1];
      m[2] <= a[2] * b[0];
      m[3] <= a[0] * b[2];
      m[4] <= a[0] * b[1];
      m[5] <= a[1] * b[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c[0] <= PW'(m[0]) - PW'(m[1]);
      c[1] <= PW'(m[2]) - PW'(m[3]);
      c[2] <= PW'(m[4]) - PW'(m[5]);
    end
  end
endmodule
`default_nettype wire

// ===== sv/rti_dot.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rti_dot (
  input  wire logic       clk,
  input  wire logic       en,
  input  rti_pkg::edge_t  a [3],
  input  rti_pkg::cross_t b [3],
  output rti_pkg::dot_t   sum
);
  import rti_pkg::*;

  logic signed [EW+HI_W-1:0]    ph [3];
  logic signed [EW+LOW_W:0]     pl [3];
  dot_t                         term [3];

  // wide operand split into a signed high half and an unsigned low half
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ph[i] <= a[i] * $signed(b[i][PW-1:LOW_W]);
        pl[i] <= a[i] * $signed({1'b0, b[i][LOW_W-1:0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        term[i] <= (SW'(ph[i]) <<< LOW_W) + SW'(pl[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= term[0] + term[1] + term[2];
    end
  end
endmodule
`default_nettype wire

// ===== sv/rti_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rti_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic [rti_pkg::DVW-1:0]     num,
  input  wire logic [rti_pkg::SW-1:0]      den,
  input  rti_pkg::div_ctl_t                ctl_in,
  output logic [rti_pkg::COORD_WIDTH-1:0]  quo,
  output rti_pkg::div_ctl_t                ctl_out
);
  import rti_pkg::*;

  logic [DVW-1:0]         rem  [DIV_STEPS+1];
  logic [SW-1:0]          dv   [DIV_STEPS+1];
  logic [COORD_WIDTH-1:0] qb   [DIV_STEPS+1];
  div_ctl_t               ctl  [DIV_STEPS+1];

  assign rem[0] = num;
  assign dv[0]  = den;
  assign qb[0]  = '0;
  assign ctl[0] = ctl_in;

  // restoring division, one quotient bit per stage; top bit flags saturation
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    localparam int K = DIV_STEPS - 1 - s;
    logic [DVW-1:0] shifted;
    logic           ge;

    assign shifted = DVW'(dv[s]) << K;
    assign ge      = rem[s] >= shifted;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? rem[s] - shifted : rem[s];
        dv[s+1]  <= dv[s];
        qb[s+1]  <= qb[s] | (ge ? (COORD_WIDTH'(1) << K) : '0);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1] <= '0;
      end else if (en) begin
        ctl[s+1] <= ctl[s];
      end
    end
  end

  assign quo     = qb[DIV_STEPS];
  assign ctl_out = ctl[DIV_STEPS];
endmodule
`default_nettype wire

// ===== sv/ray_triangle_intersection_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted beat runs through edge, cross, dot, sign-fold, divider and output registers.
// Throughput: one triangle per cycle; the pipeline advances whenever the
// output register is empty or taken, and the divider is 32 one-bit stages.
// Reset: synchronous; clears valid bits and all configuration registers to 0.
// No clearing pass; the unit accepts beats in the cycle after reset.
module ray_triangle_intersection_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [rti_pkg::IDX_WIDTH-1:0]      cfg_index,
  input  wire logic [rti_pkg::COORD_WIDTH-1:0]    cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [rti_pkg::COORD_WIDTH-1:0] vertex0_x,
  input  wire logic signed [rti_pkg::COORD_WIDTH-1:0] vertex0_y,
  input  wire logic signed [rti_pkg::COORD_WIDTH-1:0] vertex0_z,
  input  wire logic signed [rti_pkg::COORD_WIDTH-1:0] vertex1_x,
  input  wire logic signed [rti_pkg::COORD_WIDTH-1:0] vertex1_y,
  input  wire logic signed [rti_pkg::COORD_WIDTH-1:0] vertex1_z,
  input  wire logic signed [rti_pkg::COORD_WIDTH-1:0] vertex2_x,
  input  wire logic signed [rti_pkg::COORD_WIDTH-1:0] vertex2_y,
  input  wire logic signed [rti_pkg::COORD_WIDTH-1:0] vertex2_z,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    hit,
  output logic signed [rti_pkg::COORD_WIDTH-1:0]  hit_distance
);
  import rti_pkg::*;

  coord_t                origin [3];
  coord_t                direction [3];
  logic [THR_WIDTH-1:0]  threshold;

  logic en;
  logic vld [FRONT_STAGES];

  coord_t v0 [3], v1 [3], v2 [3];
  edge_t  e1_a [3], e2_a [3], s_a [3], d_a [3];
  edge_t  e1_b [3], e2_b [3], s_b [3], d_b [3];
  edge_t  e1_c [3], e2_c [3], s_c [3], d_c [3];
  cross_t p [3], q [3];
  dot_t   det_f, un_f, vn_f, tn_f;
  dot_t   det_g, un_g, vn_g, tn_g;

  logic [SW-1:0]  th_w;
  logic signed [SW:0] uv_sum;
  logic           hit_w;
  dot_t           tabs;
  logic [DVW-1:0] num_h;
  logic [SW-1:0]  det_h;
  div_ctl_t       ctl_h, ctl_o;
  logic [COORD_WIDTH-1:0] quo;
  logic [COORD_WIDTH-1:0] mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        origin[i]    <= '0;
        direction[i] <= '0;
      end
      threshold <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_ORIGIN_X:    origin[0]    <= cfg_data;
        REG_ORIGIN_Y:    origin[1]    <= cfg_data;
        REG_ORIGIN_Z:    origin[2]    <= cfg_data;
        REG_DIRECTION_X: direction[0] <= cfg_data;
        REG_DIRECTION_Y: direction[1] <= cfg_data;
        REG_DIRECTION_Z: direction[2] <= cfg_data;
        REG_THRESHOLD:   threshold    <= cfg_data[THR_WIDTH-1:0];
        default:         ;
      endcase
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign v0[0] = vertex0_x; assign v0[1] = vertex0_y; assign v0[2] = vertex0_z;
  assign v1[0] = vertex1_x; assign v1[1] = vertex1_y; assign v1[2] = vertex1_z;
  assign v2[0] = vertex2_x; assign v2[1] = vertex2_y; assign v2[2] = vertex2_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRONT_STAGES; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < FRONT_STAGES; i++) vld[i] <= vld[i-1];
    end
  end

  // edges and origin offset; the two following stages delay them beside the crosses
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_a[i] <= EW'(v1[i]) - EW'(v0[i]);
        e2_a[i] <= EW'(v2[i]) - EW'(v0[i]);
        s_a[i]  <= EW'(origin[i]) - EW'(v0[i]);
        d_a[i]  <= EW'(direction[i]);
        e1_b[i] <= e1_a[i]; e2_b[i] <= e2_a[i]; s_b[i] <= s_a[i]; d_b[i] <= d_a[i];
        e1_c[i] <= e1_b[i]; e2_c[i] <= e2_b[i]; s_c[i] <= s_b[i]; d_c[i] <= d_b[i];
      end
    end
  end

  rti_cross u_cross_p (.clk(clk), .en(en), .a(d_a), .b(e2_a), .c(p));
  rti_cross u_cross_q (.clk(clk), .en(en), .a(s_a), .b(e1_a), .c(q));

  rti_dot u_dot_det (.clk(clk), .en(en), .a(e1_c), .b(p), .sum(det_f));
  rti_dot u_dot_un  (.clk(clk), .en(en), .a(s_c),  .b(p), .sum(un_f));
  rti_dot u_dot_vn  (.clk(clk), .en(en), .a(d_c),  .b(q), .sum(vn_f));
  rti_dot u_dot_tn  (.clk(clk), .en(en), .a(e2_c), .b(q), .sum(tn_f));

  // fold the sign of det into all numerators
  always_ff @(posedge clk) begin
    if (en) begin
      if (det_f < 0) begin
        det_g <= -det_f; un_g <= -un_f; vn_g <= -vn_f; tn_g <= -tn_f;
      end else begin
        det_g <= det_f;  un_g <= un_f;  vn_g <= vn_f;  tn_g <= tn_f;
      end
    end
  end

  assign th_w   = SW'(threshold) << TH_SHIFT;
  assign uv_sum = (SW+1)'(un_g) + (SW+1)'(vn_g);
  assign hit_w  = (det_g > $signed(th_w)) && (un_g >= 0) && (un_g <= det_g)
                  && (vn_g >= 0) && (uv_sum <= (SW+1)'(det_g));
  assign tabs   = (tn_g < 0) ? -tn_g : tn_g;

  always_ff @(posedge clk) begin
    if (en) begin
      num_h <= DVW'(unsigned'(tabs)) << FRAC_BITS;
      det_h <= unsigned'(det_g);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_h <= '0;
    end else if (en) begin
      ctl_h.vld  <= vld[FRONT_STAGES-1];
      ctl_h.hit  <= hit_w;
      ctl_h.tneg <= tn_g < 0;
    end
  end

  rti_divider u_div (
    .clk(clk), .rst(rst), .en(en), .num(num_h), .den(det_h),
    .ctl_in(ctl_h), .quo(quo), .ctl_out(ctl_o)
  );

  always_comb begin
    if (quo[COORD_WIDTH-1]) begin
      mag = ctl_o.tneg ? (COORD_WIDTH'(1) << (COORD_WIDTH-1))
                       : ({COORD_WIDTH{1'b1}} >> 1);
    end else begin
      mag = {1'b0, quo[COORD_WIDTH-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl_o.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit          <= ctl_o.hit;
      hit_distance <= !ctl_o.hit ? '0 : (ctl_o.tneg ? -mag : mag);
    end
  end

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> hit_distance == '0)
    else $error("miss with nonzero distance");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");
endmodule
`default_nettype wire

// ===== bench/tb_ray_triangle_intersection_unit.sv =====
`timescale 1ns / 1ps
module tb_ray_triangle_intersection_unit;
  import rti_pkg::*;

  localparam int ONE        = 1 << FRAC_BITS;
  localparam int LATENCY    = 41;
  localparam int STUCK_LIMIT = 4000;

  // wide enough for the cross/dot products and the shifted divisor
  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic   hit;
    coord_t distance;
  } verdict_t;

  class intersect_board;
    coord_t   org[3];
    coord_t   dir[3];
    logic [THR_WIDTH-1:0] thr;
    verdict_t awaited[$];
    int       mismatches;
    int       triangles;
    int       checked;
    int       hits;

    function void set_reg(reg_index_t idx, logic [COORD_WIDTH-1:0] val);
      case (idx)
        REG_ORIGIN_X:    org[0] = val;
        REG_ORIGIN_Y:    org[1] = val;
        REG_ORIGIN_Z:    org[2] = val;
        REG_DIRECTION_X: dir[0] = val;
        REG_DIRECTION_Y: dir[1] = val;
        REG_DIRECTION_Z: dir[2] = val;
        REG_THRESHOLD:   thr = val[THR_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    function verdict_t trace_triangle(coord_t v[9]);
      wide_t e1[3], e2[3], s[3], d[3], p[3], q[3];
      wide_t det, un, vn, tn, num;
      logic tneg;
      logic [COORD_WIDTH-1:0] mag;
      verdict_t r;
      for (int i = 0; i < 3; i++) begin
        e1[i] = wide_t'(v[3+i]) - wide_t'(v[i]);
        e2[i] = wide_t'(v[6+i]) - wide_t'(v[i]);
        s[i]  = wide_t'(org[i]) - wide_t'(v[i]);
        d[i]  = wide_t'(dir[i]);
      end
      p[0] = d[1]*e2[2] - d[2]*e2[1];
      p[1] = d[2]*e2[0] - d[0]*e2[2];
      p[2] = d[0]*e2[1] - d[1]*e2[0];
      q[0] = s[1]*e1[2] - s[2]*e1[1];
      q[1] = s[2]*e1[0] - s[0]*e1[2];
      q[2] = s[0]*e1[1] - s[1]*e1[0];
      det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
      un  = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
      vn  = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
      tn  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
      if (det < 0) begin
        det = -det; un = -un; vn = -vn; tn = -tn;
      end
      r = '0;
      if (det <= (wide_t'({1'b0, thr}) <<< TH_SHIFT)) return r;
      if (un < 0 || un > det) return r;
      if (vn < 0 || un + vn > det) return r;
      tneg = tn < 0;
      num = (tneg ? -tn : tn) <<< FRAC_BITS;
      if (num >= (det <<< (COORD_WIDTH - 1))) begin
        mag = tneg ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else begin
        mag = COORD_WIDTH'(num / det);
      end
      r.hit      = 1'b1;
      r.distance = tneg ? -mag : mag;
      return r;
    endfunction

    function void note(coord_t v[9]);
      verdict_t r;
      r = trace_triangle(v);
      awaited.push_back(r);
      triangles++;
      if (r.hit) hits++;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check(logic h, coord_t distance);
      verdict_t w;
      checked++;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected beat hit=%0b distance=%0d", h, distance));
        return;
      end
      w = awaited.pop_front();
      if (h !== w.hit)
        report_mismatch($sformatf("result %0d hit %0b, want %0b", checked, h, w.hit));
      if (distance !== w.distance)
        report_mismatch($sformatf("result %0d distance %0d, want %0d",
                                  checked, distance, w.distance));
    endtask
  endclass

  logic clk, rst;
  logic cfg_write;
  logic [IDX_WIDTH-1:0] cfg_index;
  logic [COORD_WIDTH-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall, hit;
  coord_t vtx[9];
  coord_t hit_distance;
  logic quiet;
  int stuck;
  intersect_board board;

  ray_triangle_intersection_unit dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall,
    .vertex0_x(vtx[0]), .vertex0_y(vtx[1]), .vertex0_z(vtx[2]),
    .vertex1_x(vtx[3]), .vertex1_y(vtx[4]), .vertex1_z(vtx[5]),
    .vertex2_x(vtx[6]), .vertex2_y(vtx[7]), .vertex2_z(vtx[8]),
    .out_valid, .out_stall, .hit, .hit_distance
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // beat monitors and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note(vtx);
      if (out_valid && !out_stall) board.check(hit, hit_distance);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck <= 0;
      end else begin
        stuck <= stuck + 1;
        if (stuck >= STUCK_LIMIT) begin
          $display("timeout: no beat for %0d cycles", STUCK_LIMIT);
          $display("tb_ray_triangle_intersection_unit NOT OK");
          $finish;
        end
      end
    end
  end

  // receiver back-pressure in bursts
  int stall_left;
  always @(posedge clk) begin
    logic nxt;
    nxt = 1'b0;
    if (rst || quiet) begin
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      nxt = 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 6);
      nxt = 1'b1;
    end
    out_stall <= nxt;
  end

  task write_reg(reg_index_t idx, logic [COORD_WIDTH-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  // the last beat stays valid after it is taken, so drop it first
  task drain;
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task set_ray(coord_t ox, coord_t oy, coord_t oz, coord_t dx, coord_t dy, coord_t dz,
               logic [COORD_WIDTH-1:0] th);
    drain();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIRECTION_X, dx);
    write_reg(REG_DIRECTION_Y, dy);
    write_reg(REG_DIRECTION_Z, dz);
    write_reg(REG_THRESHOLD, th);
    cfg_write <= 1'b0;
  endtask

  // drive one beat and hold it until taken; optional gap afterwards
  task send(coord_t v[9]);
    in_valid <= 1'b1;
    for (int i = 0; i < 9; i++) vtx[i] <= v[i];
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task send_units(int a, int b, int c, int d, int e, int f, int g, int h, int k);
    coord_t v[9];
    v = '{a*ONE, b*ONE, c*ONE, d*ONE, e*ONE, f*ONE, g*ONE, h*ONE, k*ONE};
    send(v);
  endtask

  task send_raw(coord_t a, coord_t b, coord_t c);
    coord_t v[9];
    v = '{a, b, c, b, c, a, c, a, b};
    send(v);
  endtask

  // triangle scattered around a point on the ray, or plain noise
  task send_random;
    coord_t v[9];
    longint tt, pt, r;
    if ($urandom_range(0, 9) < 7) begin
      tt = longint'($urandom_range(0, 16 * ONE)) - 8 * ONE;
      r  = longint'(1) << $urandom_range(13, 21);
      for (int i = 0; i < 3; i++) begin
        pt = longint'(board.org[i]) + ((tt * longint'(board.dir[i])) >>> FRAC_BITS);
        for (int j = 0; j < 3; j++)
          v[3*j+i] = coord_t'(pt + longint'($urandom_range(0, 2 * r)) - r);
      end
    end else begin
      for (int i = 0; i < 9; i++) v[i] = $urandom;
    end
    send(v);
  endtask

  task random_phase(int n);
    repeat (n) send_random();
  endtask

  initial begin
    coord_t big, tiny;
    board = new();
    rst = 1'b1; quiet = 1'b0; stuck = 0;
    cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    for (int i = 0; i < 9; i++) vtx[i] = '0;
    board.set_reg(REG_ORIGIN_X, 0); board.set_reg(REG_ORIGIN_Y, 0);
    board.set_reg(REG_ORIGIN_Z, 0); board.set_reg(REG_DIRECTION_X, 0);
    board.set_reg(REG_DIRECTION_Y, 0); board.set_reg(REG_DIRECTION_Z, 0);
    board.set_reg(REG_THRESHOLD, 0);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    big  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    tiny = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // ray down +z from the origin, exact-zero threshold
    set_ray(0, 0, 0, 0, 0, ONE, 0);
    send_units(0, 0, 0, 0, 0, 0, 0, 0, 0);          // degenerate
    send_units(-1, -1, 5, 3, -1, 5, -1, 3, 5);      // plain hit
    send_units(-1, -1, 5, -1, 3, 5, 3, -1, 5);      // reversed winding
    send_units(-1, -1, -5, 3, -1, -5, -1, 3, -5);   // behind the origin
    send_units(0, 0, 2, 2, 0, 2, 0, 2, 2);          // through v0
    send_units(-1, 0, 2, 1, 0, 2, 0, 2, 2);         // on edge v0-v1
    send_units(-2, -1, 2, 0, 0, 2, -2, 2, 2);       // through v1, u+v = 1
    send_units(1, 1, 2, 3, 1, 2, 1, 3, 2);          // outside
    send_units(0, 0, 0, 1, 0, 1, 0, 0, 3);          // parallel to the ray
    send_units(-1, -1, 30000, 3, -1, 30000, -1, 3, 30000);
    send_raw(big, big, big);
    send_raw(tiny, tiny, tiny);
    send_raw(tiny, big, 0);
    send_raw(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
    send_raw(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001);

    // tiny direction: distances saturate
    set_ray(0, 0, 0, 0, 0, 1, 0);
    send_units(-1, -1, 10, 3, -1, 10, -1, 3, 10);
    send_units(-1, -1, -10, 3, -1, -10, -1, 3, -10);
    random_phase(150);

    set_ray($urandom_range(0, 8*ONE) - 4*ONE, $urandom_range(0, 8*ONE) - 4*ONE, 0,
            $urandom_range(0, 2*ONE) - ONE, $urandom_range(0, 2*ONE) - ONE, ONE,
            {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 3))});
    random_phase(120);
    drain();                                        // sender holds off mid-phase
    random_phase(120);

    // extremes of every register
    set_ray(big, tiny, big, tiny, big, tiny, 32'h0000_FFFF);
    random_phase(150);
    set_ray(tiny, big, tiny, big, tiny, big, 32'hFFFF_0000);
    random_phase(150);

    set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(150);

    set_ray(0, 0, 0, $urandom_range(0, 4*ONE) - 2*ONE, $urandom_range(0, 4*ONE) - 2*ONE,
            $urandom_range(ONE/4, 4*ONE), $urandom_range(0, 4));
    random_phase(250);

    quiet = 1'b1;
    random_phase(340);
    in_valid <= 1'b0;

    while (board.awaited.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d triangles over seven ray setups, %0d results checked, %0d hits",
             board.triangles, board.checked, board.hits);
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("tb_ray_triangle_intersection_unit OK");
    end else begin
      $display("tb_ray_triangle_intersection_unit NOT OK");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/rti_pkg.sv
sv/rti_cross.sv
sv/rti_dot.sv
sv/rti_divider.sv
sv/ray_triangle_intersection_unit.sv
bench/tb_ray_triangle_intersection_unit.sv
